>>> rtl/csa_pkg.sv
package csa_pkg;

  localparam int VALUE_W = 32;
  localparam int TERM_W = 34;
  localparam int ACC_W = 46;
  localparam int SIM_W = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Register indexes on the configuration port.
  localparam logic REG_THREE_WAY_MODE = 1'b0;

  // One finished vector waiting for its division.
  typedef struct packed {
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] den;
    logic             three_way;
  } csa_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } csa_queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } csa_back_state_t;

endpackage

>>> rtl/csa_front.sv
module csa_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                three_way_mode,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [csa_pkg::VALUE_W-1:0]         value_a,
  input  logic [csa_pkg::VALUE_W-1:0]         value_b,
  input  logic [csa_pkg::VALUE_W-1:0]         value_c,
  input  logic                                last_field,
  input  csa_pkg::csa_queue_status_t          queue_status,
  output logic                                push,
  output csa_pkg::csa_entry_t                 push_entry
);

  localparam int TW = csa_pkg::TERM_W;
  localparam int AW = csa_pkg::ACC_W;

  logic          t_valid;
  logic [TW-1:0] t_num;
  logic [TW-1:0] t_den;
  logic          t_last;
  logic          t_mode;

  logic [AW-1:0] acc_num;
  logic [AW-1:0] acc_den;

  logic [csa_pkg::VALUE_W-1:0] min_ab, min_ac, min_bc, min_abc;
  logic [TW-1:0] term_num, term_den;
  logic [AW:0]   sum_num, sum_den;
  logic [AW-1:0] sat_num, sat_den;
  logic          advance;

  always_comb begin
    min_ab  = (value_a < value_b) ? value_a : value_b;
    min_ac  = (value_a < value_c) ? value_a : value_c;
    min_bc  = (value_b < value_c) ? value_b : value_c;
    min_abc = (min_ab < value_c) ? min_ab : value_c;
    if (three_way_mode) begin
      term_num = TW'(min_ab) + TW'(min_ac) + TW'(min_bc) - TW'(min_abc);
      term_den = TW'(value_a) + TW'(value_b) + TW'(value_c);
    end else begin
      term_num = TW'(min_ab);
      term_den = TW'(value_a) + TW'(value_b);
    end
  end

  // A last item can only leave the term register when the queue has room.
  assign advance  = !(t_valid && t_last && queue_status.full);
  assign in_ready = advance;

  always_comb begin
    sum_num = {1'b0, acc_num} + (AW + 1)'(t_num);
    sum_den = {1'b0, acc_den} + (AW + 1)'(t_den);
    sat_num = sum_num[AW] ? {AW{1'b1}} : sum_num[AW-1:0];
    sat_den = sum_den[AW] ? {AW{1'b1}} : sum_den[AW-1:0];
  end

  assign push                 = t_valid && t_last && advance;
  assign push_entry.num       = sat_num;
  assign push_entry.den       = sat_den;
  assign push_entry.three_way = t_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (advance) begin
      t_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      t_num  <= term_num;
      t_den  <= term_den;
      t_last <= last_field;
      t_mode <= three_way_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= '0;
    end else if (t_valid && advance) begin
      if (t_last) begin
        acc_num <= '0;
        acc_den <= '0;
      end else begin
        acc_num <= sat_num;
        acc_den <= sat_den;
      end
    end
  end

endmodule

>>> rtl/csa_queue.sv
module csa_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  csa_pkg::csa_entry_t        push_entry,
  input  logic                       pop,
  output csa_pkg::csa_entry_t        head,
  output csa_pkg::csa_queue_status_t status
);

  localparam int Depth = csa_pkg::QUEUE_DEPTH;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  csa_pkg::csa_entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (count == CntW'(Depth));
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/csa_back.sv
module csa_back #(
  parameter int FRAC_BITS = csa_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  csa_pkg::csa_queue_status_t   queue_status,
  input  csa_pkg::csa_entry_t          head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csa_pkg::SIM_W-1:0]    similarity,
  output logic                         zero_denominator
);

  localparam int AW = csa_pkg::ACC_W;
  localparam int WW = AW + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int CntW = $clog2(FRAC_BITS);
  localparam logic [QW-1:0] QOne = {1'b1, {FRAC_BITS{1'b0}}};

  csa_pkg::csa_back_state_t state, state_next;

  logic [WW-1:0]   n, d, r;
  logic [QW-1:0]   q;
  logic [CntW-1:0] cnt;
  logic            zero;

  logic [WW-1:0] n_load, d_load, r_shift;
  logic          r_ge;
  logic [QW-1:0] q_next;
  logic          load, start_div, step, finish_check, div_last;

  always_comb begin
    if (head.three_way) begin
      n_load = {2'b00, head.num} + {1'b0, head.num, 1'b0};
      d_load = {1'b0, head.den, 1'b0};
    end else begin
      n_load = {1'b0, head.num, 1'b0};
      d_load = {2'b00, head.den};
    end
  end

  // The partial remainder stays below the divisor, so its top bit is clear.
  assign r_shift  = {r[WW-2:0], 1'b0};
  assign r_ge     = (r_shift >= d);
  assign q_next   = {q[QW-2:0], r_ge};
  assign div_last = (cnt == CntW'(FRAC_BITS - 1));

  always_comb begin
    state_next   = state;
    load         = 1'b0;
    start_div    = 1'b0;
    step         = 1'b0;
    finish_check = 1'b0;
    case (state)
      csa_pkg::BK_IDLE: begin
        if (!queue_status.empty) begin
          load       = 1'b1;
          state_next = csa_pkg::BK_CHECK;
        end
      end
      csa_pkg::BK_CHECK: begin
        if (zero || n >= d) begin
          finish_check = 1'b1;
          state_next   = csa_pkg::BK_DONE;
        end else begin
          start_div  = 1'b1;
          state_next = csa_pkg::BK_DIV;
        end
      end
      csa_pkg::BK_DIV: begin
        step = 1'b1;
        if (div_last) begin
          state_next = csa_pkg::BK_DONE;
        end
      end
      csa_pkg::BK_DONE: begin
        if (out_ready) begin
          state_next = csa_pkg::BK_IDLE;
        end
      end
      default: state_next = csa_pkg::BK_IDLE;
    endcase
  end

  assign pop       = load;
  assign out_valid = (state == csa_pkg::BK_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csa_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n    <= n_load;
      d    <= d_load;
      zero <= (head.den == '0);
    end
    if (finish_check) begin
      similarity       <= zero ? '0 : csa_pkg::SIM_W'(QOne);
      zero_denominator <= zero;
    end
    if (start_div) begin
      r   <= n;
      q   <= '0;
      cnt <= '0;
    end
    if (step) begin
      r   <= r_ge ? r_shift - d : r_shift;
      q   <= q_next;
      cnt <= cnt + 1'b1;
      if (div_last) begin
        similarity       <= csa_pkg::SIM_W'(q_next);
        zero_denominator <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/czekanowski_similarity_accumulator.sv
// Czekanowski similarity accumulator. Each item carries one element of two
// or three nonnegative vectors, and a vector streams in at one item per
// clock unless in_ready stalls it. The item marked last_field closes the
// vector; its sums pass through a two-entry queue to a restoring divider
// that produces one quotient bit per cycle. Short vectors throttle the
// input once the queue fills. A result passes from the term register
// through the queue and the check state, and through the divider only when
// the ratio lies below one. The mode register selects two-way (0) or
// three-way (1) and is written over the APB port at address 0; the user
// must write it only while the block is idle, as the block itself does not
// enforce this.
module czekanowski_similarity_accumulator #(
  parameter int FRAC_BITS = csa_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [csa_pkg::VALUE_W-1:0]  value_a,
  input  logic [csa_pkg::VALUE_W-1:0]  value_b,
  input  logic [csa_pkg::VALUE_W-1:0]  value_c,
  input  logic                         last_field,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csa_pkg::SIM_W-1:0]    similarity,
  output logic                         zero_denominator
);

  logic three_way_mode;
  logic reg_index;

  csa_pkg::csa_queue_status_t queue_status;
  csa_pkg::csa_entry_t        push_entry, head;
  logic                       push, pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      three_way_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 reg_index == csa_pkg::REG_THREE_WAY_MODE) begin
      three_way_mode <= pwdata[0];
    end
  end

  always_comb begin
    case (reg_index)
      csa_pkg::REG_THREE_WAY_MODE: prdata = {31'b0, three_way_mode};
      default:                     prdata = '0;
    endcase
  end

  csa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .three_way_mode (three_way_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value_a        (value_a),
    .value_b        (value_b),
    .value_c        (value_c),
    .last_field     (last_field),
    .queue_status   (queue_status),
    .push           (push),
    .push_entry     (push_entry)
  );

  csa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  csa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .queue_status     (queue_status),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .similarity       (similarity),
    .zero_denominator (zero_denominator)
  );

  // The queue is never written when full nor read when empty.
  assert property (@(posedge clk) disable iff (rst)
    !(push && queue_status.full) && !(pop && queue_status.empty))
    else $error("queue overrun or underrun");

  assert property (@(posedge clk) disable iff (rst)
    !(queue_status.full && queue_status.empty))
    else $error("queue reports full and empty together");

  // A zero denominator always comes with a zero similarity.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_denominator) |-> (similarity == '0))
    else $error("zero denominator with nonzero similarity");

endmodule
